// File: design/bayer_superpixel_debayer_core_macros.svh
// Assertion macros for the superpixel debayer block.
// Included by the top level; no other dependencies.
`ifndef BAYER_SUPERPIXEL_DEBAYER_CORE_MACROS_SVH
`define BAYER_SUPERPIXEL_DEBAYER_CORE_MACROS_SVH
`ifndef SYNTH
`define BSD_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle check failed");
`define BSD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");
`else
`define BSD_ASSERT_SAME(lbl, clk, rst_n, ante, cons)
`define BSD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

// File: design/bsd_pkg.sv
// Shared constants for the superpixel debayer block.
// Register indexes, register widths and reset values; no dependencies.
package bsd_pkg;

    localparam int CFG_DATA_W   = 16;
    localparam int FRAME_W_BITS = 13;
    localparam int FRAME_H_BITS = 16;

    typedef enum logic [0:0] {
        REG_FRAME_WIDTH  = 1'b0,
        REG_FRAME_HEIGHT = 1'b1
    } bsd_reg_index_t;

    localparam logic [FRAME_W_BITS-1:0] FRAME_WIDTH_RESET  = 13'd1920;
    localparam logic [FRAME_H_BITS-1:0] FRAME_HEIGHT_RESET = 16'd1080;

endpackage

// File: design/bayer_superpixel_debayer_core.sv
// Superpixel debayer for RGGB raw frames: top level.
// Depends on bsd_pkg, bsd_ram and bayer_superpixel_debayer_core_macros.svh.
//
// Usage:
//   Raw samples enter in raster order on raw_pixel with raw_valid/raw_ready.
//   Every 2x2 block gives one beat on red/green/blue/frame_end with
//   rgb_valid/rgb_ready; frame_end marks the last block of the frame.
//   Even rows are written to a line store split into an even-column and an
//   odd-column bank. On an odd row, the even-column beat issues the bank read
//   and the odd-column beat builds the result from the registered read data.
//   Throughput: one raw beat per cycle while raw_ready is high; set by the one
//   bank read per block, issued on the beat before it is needed.
//   Output: each result is registered in the result register or the skid entry.
//   Stall: a result register plus one skid entry; raw_ready drops only when
//   both hold results, and rises again the cycle after the receiver takes one.
//   Reset: counters and handshake state clear, frame_width returns to 1920
//   and frame_height to 1080. The line store is not cleared; a frame's even
//   row is always written before it is read.
//   Configuration: write cfg_index/cfg_data with cfg_write_en between frames.
`include "bayer_superpixel_debayer_core_macros.svh"

module bayer_superpixel_debayer_core
    import bsd_pkg::*;
#(
    parameter int MAX_WIDTH  = 4096,
    parameter int PIXEL_BITS = 16
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_write_en,
    input  logic [0:0]            cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  raw_valid,
    output logic                  raw_ready,
    input  logic [PIXEL_BITS-1:0] raw_pixel,
    output logic                  rgb_valid,
    input  logic                  rgb_ready,
    output logic [PIXEL_BITS-1:0] red,
    output logic [PIXEL_BITS-1:0] green,
    output logic [PIXEL_BITS-1:0] blue,
    output logic                  frame_end
);

    localparam int COL_W     = $clog2(MAX_WIDTH);
    localparam int WID_W     = $clog2(MAX_WIDTH + 1);
    localparam int BANK_D    = MAX_WIDTH / 2;
    localparam int BANK_AW   = (BANK_D > 1) ? $clog2(BANK_D) : 1;

    // configuration
    logic [FRAME_W_BITS-1:0] frame_width_reg;
    logic [FRAME_H_BITS-1:0] frame_height_reg;

    // position and left green sample
    logic [COL_W-1:0]        col_reg;
    logic [COL_W-1:0]        col_next;
    logic [FRAME_H_BITS-1:0] row_reg;
    logic [FRAME_H_BITS-1:0] row_next;
    logic [PIXEL_BITS-1:0]   left_odd_reg;

    // result register and skid entry
    logic                  rgb_valid_reg;
    logic [PIXEL_BITS-1:0] red_reg;
    logic [PIXEL_BITS-1:0] green_reg;
    logic [PIXEL_BITS-1:0] blue_reg;
    logic                  frame_end_reg;
    logic                  skid_valid_reg;
    logic [PIXEL_BITS-1:0] skid_red_reg;
    logic [PIXEL_BITS-1:0] skid_green_reg;
    logic [PIXEL_BITS-1:0] skid_blue_reg;
    logic                  skid_end_reg;

    logic [WID_W-1:0]        eff_w;
    logic [WID_W-1:0]        even_w;
    logic [WID_W-1:0]        col_ext;
    logic [FRAME_H_BITS-1:0] eff_h;
    logic [FRAME_H_BITS-1:0] even_h;
    logic                    raw_fire;
    logic                    rgb_fire;
    logic                    in_block;
    logic                    emit;
    logic                    last_block;
    logic                    col_wrap;
    logic                    row_wrap;
    logic [COL_W-1:0]        col_half;
    logic [BANK_AW-1:0]      bank_addr;
    logic                    even_bank_we;
    logic                    odd_bank_we;
    logic                    bank_re;
    logic [PIXEL_BITS-1:0]   even_bank_q;
    logic [PIXEL_BITS-1:0]   odd_bank_q;
    logic [PIXEL_BITS:0]     green_sum;
    logic [PIXEL_BITS-1:0]   green_new;

    // clamp the frame size
    always_comb
    begin
        if (frame_width_reg < FRAME_W_BITS'(2))
        begin
            eff_w = WID_W'(2);
        end
        else if (32'(frame_width_reg) > 32'(MAX_WIDTH))
        begin
            eff_w = WID_W'(MAX_WIDTH);
        end
        else
        begin
            eff_w = WID_W'(frame_width_reg);
        end
        if (frame_height_reg < FRAME_H_BITS'(2))
        begin
            eff_h = FRAME_H_BITS'(2);
        end
        else
        begin
            eff_h = frame_height_reg;
        end
    end

    assign even_w  = {eff_w[WID_W-1:1], 1'b0};
    assign even_h  = {eff_h[FRAME_H_BITS-1:1], 1'b0};
    assign col_ext = WID_W'(col_reg);

    assign raw_ready = !skid_valid_reg;
    assign raw_fire  = raw_valid && raw_ready;
    assign rgb_fire  = rgb_valid_reg && rgb_ready;

    assign in_block   = (col_ext < even_w) && (row_reg < even_h);
    assign emit       = in_block && row_reg[0] && col_reg[0];
    assign last_block = (row_reg == even_h - FRAME_H_BITS'(1))
                     && (col_ext == even_w - WID_W'(1));
    assign col_wrap   = col_ext >= eff_w - WID_W'(1);
    assign row_wrap   = row_reg >= eff_h - FRAME_H_BITS'(1);

    always_comb
    begin
        if (col_wrap)
        begin
            col_next = '0;
            row_next = row_wrap ? '0 : row_reg + FRAME_H_BITS'(1);
        end
        else
        begin
            col_next = col_reg + COL_W'(1);
            row_next = row_reg;
        end
    end

    // even row: write each sample to its column bank; odd row: read on even column
    assign col_half     = col_reg >> 1;
    assign bank_addr    = BANK_AW'(col_half);
    assign even_bank_we = raw_fire && in_block && !row_reg[0] && !col_reg[0];
    assign odd_bank_we  = raw_fire && in_block && !row_reg[0] && col_reg[0];
    assign bank_re      = raw_fire && row_reg[0] && !col_reg[0];

    bsd_ram #(
        .WIDTH (PIXEL_BITS),
        .DEPTH (BANK_D)
    ) u_even_bank (
        .clk     (clk),
        .wr_en   (even_bank_we),
        .wr_addr (bank_addr),
        .wr_data (raw_pixel),
        .rd_en   (bank_re),
        .rd_addr (bank_addr),
        .rd_data (even_bank_q)
    );

    bsd_ram #(
        .WIDTH (PIXEL_BITS),
        .DEPTH (BANK_D)
    ) u_odd_bank (
        .clk     (clk),
        .wr_en   (odd_bank_we),
        .wr_addr (bank_addr),
        .wr_data (raw_pixel),
        .rd_en   (bank_re),
        .rd_addr (bank_addr),
        .rd_data (odd_bank_q)
    );

    assign green_sum = {1'b0, odd_bank_q} + {1'b0, left_odd_reg};
    assign green_new = green_sum[PIXEL_BITS:1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_width_reg  <= FRAME_WIDTH_RESET;
            frame_height_reg <= FRAME_HEIGHT_RESET;
        end
        else if (cfg_write_en)
        begin
            unique case (cfg_index)
                REG_FRAME_WIDTH:  frame_width_reg  <= cfg_data[FRAME_W_BITS-1:0];
                REG_FRAME_HEIGHT: frame_height_reg <= cfg_data[FRAME_H_BITS-1:0];
                default:          frame_width_reg  <= frame_width_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg      <= '0;
            row_reg      <= '0;
            left_odd_reg <= '0;
        end
        else if (raw_fire)
        begin
            col_reg <= col_next;
            row_reg <= row_next;
            if (in_block && row_reg[0] && !col_reg[0])
            begin
                left_odd_reg <= raw_pixel;
            end
        end
    end

    // result register with one skid entry behind it
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rgb_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (skid_valid_reg)
        begin
            if (rgb_fire)
            begin
                skid_valid_reg <= 1'b0;
            end
        end
        else if (raw_fire && emit)
        begin
            if (rgb_valid_reg && !rgb_fire)
            begin
                skid_valid_reg <= 1'b1;
            end
            rgb_valid_reg <= 1'b1;
        end
        else if (rgb_fire)
        begin
            rgb_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (skid_valid_reg)
        begin
            if (rgb_fire)
            begin
                red_reg       <= skid_red_reg;
                green_reg     <= skid_green_reg;
                blue_reg      <= skid_blue_reg;
                frame_end_reg <= skid_end_reg;
            end
        end
        else if (raw_fire && emit)
        begin
            if (rgb_valid_reg && !rgb_fire)
            begin
                skid_red_reg   <= even_bank_q;
                skid_green_reg <= green_new;
                skid_blue_reg  <= raw_pixel;
                skid_end_reg   <= last_block;
            end
            else
            begin
                red_reg       <= even_bank_q;
                green_reg     <= green_new;
                blue_reg      <= raw_pixel;
                frame_end_reg <= last_block;
            end
        end
    end

    assign rgb_valid = rgb_valid_reg;
    assign red       = red_reg;
    assign green     = green_reg;
    assign blue      = blue_reg;
    assign frame_end = frame_end_reg;

    `BSD_ASSERT_SAME(a_skid_behind_result, clk, rst_n, skid_valid_reg, rgb_valid_reg)
    `BSD_ASSERT_NEXT(a_frame_wrap, clk, rst_n, raw_fire && col_wrap && row_wrap, (col_reg == '0) && (row_reg == '0))
    `BSD_ASSERT_NEXT(a_no_phantom_result, clk, rst_n, !rgb_valid_reg && !(raw_fire && emit), !rgb_valid_reg)

endmodule

// File: design/bsd_ram.sv
// Generic single-write, single-read RAM with registered read data.
// Used for the line-store banks; no package dependencies.
module bsd_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 2048
) (
    input  logic                                  clk,
    input  logic                                  wr_en,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                      wr_data,
    input  logic                                  rd_en,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [WIDTH-1:0]                      rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule
